// File: design/b85_pkg.sv
// ----------------------------------------------------------------------------
// b85_pkg
// Shared types, constants and helper functions for the base-85 word encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b85_pkg;

   localparam int unsigned B85_WORD_W   = 32;
   localparam int unsigned B85_QUO_W    = 26;   // 2^32 / 85 fits in 26 bits
   localparam int unsigned B85_DIGIT_W  = 7;    // digits run 0..84
   localparam int unsigned B85_CHAR_W   = 8;
   localparam int unsigned B85_COUNT_W  = 3;
   localparam int unsigned B85_LOW_DIGITS = 4;  // digits peeled off by the cells

   // floor(v / 85) == (v * B85_RECIP) >> B85_RECIP_SHIFT for every 32-bit v
   localparam logic [31:0] B85_RECIP       = 32'hC0C0C0C1;
   localparam int unsigned B85_RECIP_SHIFT = 38;
   localparam logic [31:0] B85_RADIX       = 32'd85;

   localparam logic [B85_CHAR_W-1:0]  B85_ZERO_CHAR  = 8'h7A;   // 'z'
   localparam logic [B85_CHAR_W-1:0]  B85_NULL_CHAR  = 8'h00;
   localparam logic [B85_COUNT_W-1:0] B85_COUNT_FULL = 3'd5;
   localparam logic [B85_COUNT_W-1:0] B85_COUNT_ZERO = 3'd1;

   // One word in flight through the divider chain.
   typedef struct packed {
      logic                                        last;
      logic                                        zero;
      logic [B85_WORD_W-1:0]                       num;    // dividend of this step
      logic [B85_QUO_W-1:0]                        quo;    // num / 85
      logic [B85_LOW_DIGITS-1:0][B85_DIGIT_W-1:0]  digit;  // shifted in at [0]
   } b85_token_type;

   function automatic logic [B85_QUO_W-1:0] b85_div85(input logic [B85_WORD_W-1:0] v);
      logic [2*B85_WORD_W-1:0] prod;
      prod = {{B85_WORD_W{1'b0}}, v} * {{B85_WORD_W{1'b0}}, B85_RECIP};
      return prod[B85_RECIP_SHIFT +: B85_QUO_W];
   endfunction

   // RFC 1924 alphabet lookup.
   function automatic logic [B85_CHAR_W-1:0] b85_char(input logic [B85_DIGIT_W-1:0] d);
      logic [B85_CHAR_W-1:0] c;
      c = B85_NULL_CHAR;
      if (d < 7'd10) begin
         c = 8'h30 + {1'b0, d};
      end else if (d < 7'd36) begin
         c = 8'h41 + {1'b0, d} - 8'd10;
      end else if (d < 7'd62) begin
         c = 8'h61 + {1'b0, d} - 8'd36;
      end else begin
         case (d)
            7'd62:   c = 8'h21;  // !
            7'd63:   c = 8'h23;  // #
            7'd64:   c = 8'h24;  // $
            7'd65:   c = 8'h25;  // %
            7'd66:   c = 8'h26;  // &
            7'd67:   c = 8'h28;  // (
            7'd68:   c = 8'h29;  // )
            7'd69:   c = 8'h2A;  // *
            7'd70:   c = 8'h2B;  // +
            7'd71:   c = 8'h2D;  // -
            7'd72:   c = 8'h3B;  // ;
            7'd73:   c = 8'h3C;  // <
            7'd74:   c = 8'h3D;  // =
            7'd75:   c = 8'h3E;  // >
            7'd76:   c = 8'h3F;  // ?
            7'd77:   c = 8'h40;  // @
            7'd78:   c = 8'h5E;  // ^
            7'd79:   c = 8'h5F;  // _
            7'd80:   c = 8'h60;  // backtick
            7'd81:   c = 8'h7B;  // {
            7'd82:   c = 8'h7C;  // |
            7'd83:   c = 8'h7D;  // }
            7'd84:   c = 8'h7E;  // ~
            default: c = B85_NULL_CHAR;
         endcase
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: design/b85_req_if.sv
// ----------------------------------------------------------------------------
// b85_req_if
// Input channel: one 32-bit word and its end-of-buffer flag per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface b85_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] word;
   logic        last_word;

   modport source (output valid, word, last_word, input ready);
   modport sink   (input valid, word, last_word, output ready);
endinterface

`default_nettype wire

// File: design/b85_rsp_if.sv
// ----------------------------------------------------------------------------
// b85_rsp_if
// Result channel: one group of up to five base-85 characters per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface b85_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_0;
   logic [7:0] char_1;
   logic [7:0] char_2;
   logic [7:0] char_3;
   logic [7:0] char_4;
   logic [2:0] char_count;
   logic       last_group;

   modport source (output valid, char_0, char_1, char_2, char_3, char_4,
                   char_count, last_group, input ready);
   modport sink   (input valid, char_0, char_1, char_2, char_3, char_4,
                   char_count, last_group, output ready);
endinterface

`default_nettype wire

// File: design/base85_word_encoder_top.sv
// ----------------------------------------------------------------------------
// base85_word_encoder_top
// Base-85 (RFC 1924 alphabet) encoder, one 32-bit word per transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries one big-endian word; each result transfer
// carries its text, most significant digit in char_0. A nonzero word gives
// five characters (char_count = 5). A zero word gives the single character
// 'z' (char_count = 1, char_1..char_4 read 0). Note 'z' is also digit 61, so
// a nonzero word can emit 'z' too. last_word rides along as last_group.
// Throughput is one word per clock with the result side ready. The word
// passes six registers: an entry register that starts the first divide by
// 85 and loads at the transfer edge, four divider cells in a row, and the
// output register with the alphabet lookup. Each stage has its own valid
// and holds its word only while the next stage is full and stalled, so the
// input keeps taking words into empty stages while a finished result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module base85_word_encoder_top import b85_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   b85_req_if.sink   req_chan,
   b85_rsp_if.source rsp_chan
);

   localparam int unsigned NUM_CELLS = B85_LOW_DIGITS;

   // Entry register: captures the word and its first quotient.
   logic          entry_valid_ff, entry_valid_in;
   b85_token_type entry_tok_ff, entry_tok_in;

   // Handshake between neighbors along the chain; index 0 is the entry stage.
   logic          chain_valid [NUM_CELLS+1];
   b85_token_type chain_tok   [NUM_CELLS+1];
   logic          chain_ready [NUM_CELLS+1];

   assign req_chan.ready = !entry_valid_ff || chain_ready[0];
   assign entry_valid_in = req_chan.ready ? req_chan.valid : entry_valid_ff;

   always_comb begin
      entry_tok_in       = '0;
      entry_tok_in.last  = req_chan.last_word;
      entry_tok_in.zero  = (req_chan.word == '0);
      entry_tok_in.num   = req_chan.word;
      entry_tok_in.quo   = b85_div85(req_chan.word);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         entry_tok_ff <= entry_tok_in;
      end
   end

   assign chain_valid[0] = entry_valid_ff;
   assign chain_tok[0]   = entry_tok_ff;

   // Divider cells: each one emits the next digit, least significant first.
   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      b85_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[g]),
         .up_tok   (chain_tok[g]),
         .up_ready (chain_ready[g]),
         .dn_valid (chain_valid[g+1]),
         .dn_tok   (chain_tok[g+1]),
         .dn_ready (chain_ready[g+1])
      );
   end

   // Alphabet lookup and result register.
   b85_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .up_valid (chain_valid[NUM_CELLS]),
      .up_tok   (chain_tok[NUM_CELLS]),
      .up_ready (chain_ready[NUM_CELLS]),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// File: design/b85_cell.sv
// ----------------------------------------------------------------------------
// b85_cell
// One divide-by-85 step: peels the low digit off and pre-divides the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module b85_cell import b85_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          up_valid,
   input  wire b85_token_type up_tok,
   output logic               up_ready,
   output logic               dn_valid,
   output b85_token_type      dn_tok,
   input  wire logic          dn_ready
);

   logic          valid_ff, valid_in;
   b85_token_type tok_ff, tok_in;
   logic [B85_WORD_W-1:0] quo_x85;
   logic [B85_WORD_W-1:0] rem;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // remainder = num - 85*quo, with 85*quo as shifts and adds
   always_comb begin
      quo_x85 = {{(B85_WORD_W-B85_QUO_W){1'b0}}, up_tok.quo};
      quo_x85 = (quo_x85 << 6) + (quo_x85 << 4) + (quo_x85 << 2) + quo_x85;
      rem     = up_tok.num - quo_x85;

      tok_in       = up_tok;
      tok_in.num   = {{(B85_WORD_W-B85_QUO_W){1'b0}}, up_tok.quo};
      tok_in.quo   = b85_div85({{(B85_WORD_W-B85_QUO_W){1'b0}}, up_tok.quo});
      tok_in.digit = {up_tok.digit[B85_LOW_DIGITS-2:0], rem[B85_DIGIT_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         tok_ff <= tok_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_tok   = tok_ff;

endmodule

`default_nettype wire

// File: design/b85_out_stage.sv
// ----------------------------------------------------------------------------
// b85_out_stage
// Alphabet lookup and the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module b85_out_stage import b85_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          up_valid,
   input  wire b85_token_type up_tok,
   output logic               up_ready,
   b85_rsp_if.source          rsp_chan
);

   logic                   valid_ff, valid_in;
   logic [B85_CHAR_W-1:0]  char0_ff, char1_ff, char2_ff, char3_ff, char4_ff;
   logic [B85_CHAR_W-1:0]  char0_in, char1_in, char2_in, char3_in, char4_in;
   logic [B85_COUNT_W-1:0] count_ff, count_in;
   logic                   last_ff;

   assign up_ready = !valid_ff || rsp_chan.ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      if (up_tok.zero) begin
         char0_in = B85_ZERO_CHAR;
         char1_in = B85_NULL_CHAR;
         char2_in = B85_NULL_CHAR;
         char3_in = B85_NULL_CHAR;
         char4_in = B85_NULL_CHAR;
         count_in = B85_COUNT_ZERO;
      end else begin
         // num holds the top digit once all low digits are peeled off
         char0_in = b85_char(up_tok.num[B85_DIGIT_W-1:0]);
         char1_in = b85_char(up_tok.digit[0]);
         char2_in = b85_char(up_tok.digit[1]);
         char3_in = b85_char(up_tok.digit[2]);
         char4_in = b85_char(up_tok.digit[3]);
         count_in = B85_COUNT_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         char0_ff <= char0_in;
         char1_ff <= char1_in;
         char2_ff <= char2_in;
         char3_ff <= char3_in;
         char4_ff <= char4_in;
         count_ff <= count_in;
         last_ff  <= up_tok.last;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.char_0     = char0_ff;
   assign rsp_chan.char_1     = char1_ff;
   assign rsp_chan.char_2     = char2_ff;
   assign rsp_chan.char_3     = char3_ff;
   assign rsp_chan.char_4     = char4_ff;
   assign rsp_chan.char_count = count_ff;
   assign rsp_chan.last_group = last_ff;

endmodule

`default_nettype wire
